>>> hw/rtl/contiguous_page_frame_allocator_macros.svh
`ifndef CONTIGUOUS_PAGE_FRAME_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_PAGE_FRAME_ALLOCATOR_MACROS_SVH

// check prop on every rising clock edge outside reset
`define CPFA_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// check that cond never holds
`define CPFA_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

>>> hw/rtl/cpfa_pkg.sv
package cpfa_pkg;

	localparam int MAX_FRAMES_DEF = 1024;
	localparam int PAGE_BYTES_DEF = 4096;

	localparam int ADDR_W    = 32;
	localparam int ENTRY_W   = 11;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'b1;

	localparam logic [ENTRY_W-1:0] FRAME_COUNT_RST = 11'd1024;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NO_SPACE = 2'd1,
		ST_BAD_FREE = 2'd2
	} status_t;

endpackage

>>> hw/rtl/cpfa_ram.sv
module cpfa_ram #(
	parameter int WIDTH = 11,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/contiguous_page_frame_allocator.sv
// channel  | handshake             | word
// ---------+-----------------------+---------------------------------------
// in       | in_valid / in_ready   | operation, page_count, block_address
// out      | out_valid / out_ready | status, granted_address
// cfg      | cfg_we                | cfg_index, cfg_data
//
// Allocate: accept, scan the map up to the frame limit (one read per cycle), mark the
// pages of the run, load the result; a zero-page allocate goes straight to the result.
// Free: check the frame index, read the first entry, then clear entries while the walk
// continues the run; an address below base, or an index past the frames, gives ST_BAD_FREE.
// PAGE_BYTES must be a power of two, which the block does not check: the frame index is the
// address offset shifted right. After reset the map is cleared one entry per cycle, with
// in_ready low until every entry is clear. The next word is taken while a result waits in
// the output register; a finished item holds until that register is free.
`include "contiguous_page_frame_allocator_macros.svh"

module contiguous_page_frame_allocator
	import cpfa_pkg::*;
#(
	parameter int MAX_FRAMES = MAX_FRAMES_DEF,
	parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 operation,
	input  logic [ENTRY_W-1:0]   page_count,
	input  logic [ADDR_W-1:0]    block_address,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [1:0]           status,
	output logic [ADDR_W-1:0]    granted_address
);

	localparam int IDX_W = $clog2(MAX_FRAMES);
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int PB_W  = $clog2(PAGE_BYTES);
	localparam int SUM_W = (IDX_W > ENTRY_W ? IDX_W : ENTRY_W) + 1;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_CHK,
		S_WRD,
		S_WALK,
		S_DONE
	} state_t;

	state_t                 state_q;
	logic [ADDR_W-1:0]      base_q;
	logic [ENTRY_W-1:0]     frame_count_q;
	logic [ENTRY_W-1:0]     pages_q;
	logic [CNT_W-1:0]       ptr_q;
	logic                   rd_valid_s1;
	logic [IDX_W-1:0]       idx_s1;
	logic [ENTRY_W-1:0]     run_q;
	logic [IDX_W-1:0]       start_q;
	logic [ENTRY_W-1:0]     fill_q;
	logic [ADDR_W-1:0]      prod_q;
	logic [ADDR_W-1:0]      quot_q;
	logic [ENTRY_W-1:0]     cur_q;
	logic                   first_q;
	status_t                res_status_q;
	logic                   res_grant_q;
	logic                   out_valid_q;
	logic [1:0]             status_q;
	logic [ADDR_W-1:0]      granted_q;

	logic [CNT_W-1:0]       limit;
	logic [CNT_W-1:0]       ptr_nx;
	logic                   issue;
	logic                   found;
	logic                   scan_empty;
	logic                   hit;
	logic                   fill_last;
	logic [SUM_W-1:0]       fill_sum;
	logic                   out_load;

	logic                   map_we;
	logic [IDX_W-1:0]       map_waddr;
	logic [ENTRY_W-1:0]     map_wdata;
	logic [IDX_W-1:0]       map_raddr;
	logic [ENTRY_W-1:0]     map_rdata;

	always_comb begin
		if (32'(frame_count_q) > 32'(MAX_FRAMES)) begin
			limit = CNT_W'(MAX_FRAMES);
		end else begin
			limit = CNT_W'(frame_count_q);
		end
	end

	assign ptr_nx     = ptr_q + CNT_W'(1);
	assign issue      = ptr_q < limit;
	assign scan_empty = (map_rdata == '0);
	assign found      = rd_valid_s1 && scan_empty &&
		(({1'b0, run_q} + (ENTRY_W + 1)'(1)) == {1'b0, pages_q});
	assign hit        = first_q ||
		({1'b0, map_rdata} == ({1'b0, cur_q} + (ENTRY_W + 1)'(1)));
	assign fill_last  = ({1'b0, fill_q} + (ENTRY_W + 1)'(1)) == {1'b0, pages_q};
	assign fill_sum   = SUM_W'(start_q) + SUM_W'(fill_q);
	assign out_load   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	always_comb begin
		map_we    = 1'b0;
		map_waddr = ptr_q[IDX_W-1:0];
		map_wdata = '0;
		map_raddr = ptr_q[IDX_W-1:0];
		case (state_q)
			S_CLEAR: begin
				map_we = 1'b1;
			end
			S_FILL: begin
				map_we    = 1'b1;
				map_waddr = fill_sum[IDX_W-1:0];
				map_wdata = fill_q + ENTRY_W'(1);
			end
			S_WALK: begin
				map_we    = hit;
				map_raddr = ptr_nx[IDX_W-1:0];
			end
			default: begin
			end
		endcase
	end

	cpfa_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_FRAMES)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			base_q        <= '0;
			frame_count_q <= FRAME_COUNT_RST;
			pages_q       <= '0;
			ptr_q         <= '0;
			rd_valid_s1   <= 1'b0;
			idx_s1        <= '0;
			run_q         <= '0;
			start_q       <= '0;
			fill_q        <= '0;
			prod_q        <= '0;
			quot_q        <= '0;
			cur_q         <= '0;
			first_q       <= 1'b0;
			res_status_q  <= ST_OK;
			res_grant_q   <= 1'b0;
			out_valid_q   <= 1'b0;
			status_q      <= '0;
			granted_q     <= '0;
		end else begin
			rd_valid_s1 <= (state_q == S_SCAN) && issue && !found;
			if (out_load) begin
				out_valid_q <= 1'b1;
				status_q    <= res_status_q;
				granted_q   <= res_grant_q ? (base_q + prod_q) : '0;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_BASE:  base_q        <= cfg_data;
					REG_COUNT: frame_count_q <= cfg_data[ENTRY_W-1:0];
					default: begin
					end
				endcase
			end
			case (state_q)
				S_CLEAR: begin
					if (ptr_q == CNT_W'(MAX_FRAMES - 1)) begin
						ptr_q   <= '0;
						state_q <= S_IDLE;
					end else begin
						ptr_q <= ptr_nx;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						pages_q <= page_count;
						ptr_q   <= '0;
						run_q   <= '0;
						if (operation == OP_FREE) begin
							res_grant_q <= 1'b0;
							if (block_address < base_q) begin
								res_status_q <= ST_BAD_FREE;
								state_q      <= S_DONE;
							end else begin
								quot_q  <= (block_address - base_q) >> PB_W;
								state_q <= S_CHK;
							end
						end else if (page_count == '0) begin
							res_status_q <= ST_OK;
							res_grant_q  <= 1'b1;
							prod_q       <= '0;
							state_q      <= S_DONE;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					if (issue) begin
						ptr_q <= ptr_nx;
					end
					idx_s1 <= ptr_q[IDX_W-1:0];
					if (rd_valid_s1) begin
						if (scan_empty) begin
							if (run_q == '0) begin
								start_q <= idx_s1;
							end
							run_q <= run_q + ENTRY_W'(1);
						end else begin
							run_q <= '0;
						end
					end
					if (found) begin
						fill_q  <= '0;
						state_q <= S_FILL;
					end else if (!rd_valid_s1 && !issue) begin
						res_status_q <= ST_NO_SPACE;
						res_grant_q  <= 1'b0;
						state_q      <= S_DONE;
					end
				end
				S_FILL: begin
					prod_q <= 32'(start_q) * 32'(PAGE_BYTES);
					fill_q <= fill_q + ENTRY_W'(1);
					if (fill_last) begin
						res_status_q <= ST_OK;
						res_grant_q  <= 1'b1;
						state_q      <= S_DONE;
					end
				end
				S_CHK: begin
					if (quot_q >= 32'(limit)) begin
						res_status_q <= ST_BAD_FREE;
						state_q      <= S_DONE;
					end else begin
						ptr_q   <= CNT_W'(quot_q[IDX_W-1:0]);
						state_q <= S_WRD;
					end
				end
				S_WRD: begin
					first_q <= 1'b1;
					state_q <= S_WALK;
				end
				S_WALK: begin
					first_q <= 1'b0;
					cur_q   <= map_rdata;
					if (hit && (ptr_nx < limit)) begin
						ptr_q <= ptr_nx;
					end else begin
						res_status_q <= ST_OK;
						state_q      <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready        = (state_q == S_IDLE);
	assign out_valid       = out_valid_q;
	assign status          = status_q;
	assign granted_address = granted_q;

	`CPFA_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "accepted word did not hold the input side")
	`CPFA_ASSERT(a_grant_only_ok, out_valid && status != ST_OK |-> granted_address == '0, "failed request granted an address")
	`CPFA_NEVER(a_scan_no_write, map_we && (state_q == S_SCAN || rd_valid_s1), "map written during scan")
	`CPFA_ASSERT(a_write_in_range, map_we && state_q != S_CLEAR |-> CNT_W'(map_waddr) < limit, "map write past managed frames")

endmodule

>>> tb/sv/contiguous_page_frame_allocator_tb.sv
`timescale 1ns / 1ps

module contiguous_page_frame_allocator_tb;
	import cpfa_pkg::*;

	localparam int MAX_FRAMES = MAX_FRAMES_DEF;
	localparam int PAGE_BYTES = PAGE_BYTES_DEF;
	localparam int NUM_PHASES = 9;
	localparam int PHASE_COUNT [NUM_PHASES] = '{16, 32, 1024, 5, 64, 2047, 1, 24, 0};
	localparam int PHASE_ITEMS [NUM_PHASES] = '{90, 90, 40, 70, 90, 20, 30, 100, 20};

	typedef struct {
		status_t           st;
		logic [ADDR_W-1:0] addr;
	} grant_t;

	typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t            kind;
		op_t                  op;
		logic [ENTRY_W-1:0]   pages;
		logic [ADDR_W-1:0]    addr;
		logic [CFG_IDX_W-1:0] sel;
		bit                   fixed;
		status_t              st;
		logic [ADDR_W-1:0]    ga;
	} script_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic                 operation = 1'b0;
	logic [ENTRY_W-1:0]   page_count = '0;
	logic [ADDR_W-1:0]    block_address = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [1:0]           status;
	logic [ADDR_W-1:0]    granted_address;

	logic [ADDR_W-1:0]  base_reg = '0;
	logic [ENTRY_W-1:0] count_reg = FRAME_COUNT_RST;
	logic [ENTRY_W-1:0] frame_tbl [MAX_FRAMES];
	grant_t             grant_queue [$];
	int                 live_runs [$];
	script_row_t        script [$];
	int                 fail_count = 0;
	int                 burst_left = 0;
	logic [9:0]         rx_tick = '0;

	contiguous_page_frame_allocator #(
		.MAX_FRAMES(MAX_FRAMES),
		.PAGE_BYTES(PAGE_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.page_count(page_count),
		.block_address(block_address),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.granted_address(granted_address)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int managed_limit();
		return (int'(count_reg) > MAX_FRAMES) ? MAX_FRAMES : int'(count_reg);
	endfunction

	function automatic void apply_word(input op_t op, input logic [ENTRY_W-1:0] pages,
			input logic [ADDR_W-1:0] addr, output grant_t res, output int first);
		int lim;
		int run;
		bit found;
		logic [ADDR_W-1:0] idx;
		logic [ENTRY_W-1:0] cur;
		lim = managed_limit();
		first = 0;
		res.st = ST_OK;
		res.addr = '0;
		if (op == OP_ALLOC) begin
			run = 0;
			found = (pages == 0);
			for (int i = 0; i < lim && !found; i++) begin
				if (frame_tbl[i] == '0) begin
					if (run == 0)
						first = i;
					run++;
					if (run == int'(pages))
						found = 1'b1;
				end else begin
					run = 0;
				end
			end
			if (!found) begin
				res.st = ST_NO_SPACE;
				return;
			end
			for (int i = 0; i < int'(pages); i++)
				frame_tbl[first + i] = ENTRY_W'(i + 1);
			res.addr = base_reg + ADDR_W'(first) * ADDR_W'(PAGE_BYTES);
		end else if (addr < base_reg) begin
			res.st = ST_BAD_FREE;
		end else begin
			idx = (addr - base_reg) / ADDR_W'(PAGE_BYTES);
			if (idx >= ADDR_W'(lim)) begin
				res.st = ST_BAD_FREE;
			end else begin
				do begin
					cur = frame_tbl[idx];
					frame_tbl[idx] = '0;
					idx++;
				end while (idx < ADDR_W'(lim) && 12'(frame_tbl[idx]) == 12'(cur) + 12'd1);
			end
		end
	endfunction

	task automatic flag_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	task automatic push_word(input op_t op, input logic [ENTRY_W-1:0] pages,
			input logic [ADDR_W-1:0] addr, input bit fixed = 1'b0,
			input status_t st = ST_OK, input logic [ADDR_W-1:0] ga = '0);
		grant_t res;
		int first;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			if ($urandom_range(0, 3) != 0) begin
				in_valid <= 1'b0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		operation     <= op;
		page_count    <= pages;
		block_address <= addr;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		apply_word(op, pages, addr, res, first);
		if (op == OP_ALLOC && res.st == ST_OK && pages != 0)
			live_runs.push_back(first);
		if (fixed) begin
			res.st = st;
			res.addr = ga;
		end
		grant_queue.push_back(res);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (grant_queue.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] sel, input logic [ADDR_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (sel == REG_BASE)
			base_reg = data;
		else
			count_reg = data[ENTRY_W-1:0];
		@(posedge clk);
	endtask

	always @(posedge clk) begin
		rx_tick <= rx_tick + 1'b1;
		case (rx_tick[9:8])
			2'd0: out_ready <= 1'b1;
			2'd1: out_ready <= 1'($urandom_range(0, 1));
			2'd2: out_ready <= ($urandom_range(0, 3) == 0);
			default: out_ready <= (rx_tick[2:0] != 3'd0);
		endcase
	end

	always @(negedge clk) begin
		grant_t want;
		if (arst_n && out_valid && out_ready) begin
			if (grant_queue.size() == 0) begin
				flag_mismatch("result word with nothing outstanding");
			end else begin
				want = grant_queue.pop_front();
				if (status !== want.st)
					flag_mismatch($sformatf("status %0d, expected %0d", status, want.st));
				if (granted_address !== want.addr)
					flag_mismatch($sformatf("granted_address %h, expected %h",
						granted_address, want.addr));
			end
		end
	end

	initial begin
		#200_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		script_row_t row;
		logic [ADDR_W-1:0] base;
		logic [ADDR_W-1:0] addr;
		logic [ENTRY_W-1:0] pages;
		int lim;
		int pick;
		int k;
		foreach (frame_tbl[i])
			frame_tbl[i] = '0;

		script.push_back('{ROW_WORD, OP_ALLOC, 11'd0,    32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1,    32'hFFFF_FFFF, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd3,    32'h0000_0000, REG_BASE, 1'b1, ST_OK,
			32'h0000_1000});
		script.push_back('{ROW_WORD, OP_FREE,  11'h7FF,  32'h0000_1000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd2,    32'h0000_0000, REG_BASE, 1'b1, ST_OK,
			32'h0000_1000});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h0000_1FFF, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h0040_0000, REG_BASE, 1'b1,
			ST_BAD_FREE, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'h7FF,  32'hFFFF_FFFF, REG_BASE, 1'b1,
			ST_BAD_FREE, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1024, 32'h0000_0000, REG_BASE, 1'b1,
			ST_NO_SPACE, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1024, 32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1,    32'h0000_0000, REG_BASE, 1'b1,
			ST_NO_SPACE, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h003F_F000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1,    32'h0000_0000, REG_BASE, 1'b1, ST_OK,
			32'h003F_F000});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h0000_8000, REG_BASE, 1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'h7FF,  32'h0000_0000, REG_BASE, 1'b1,
			ST_NO_SPACE, 32'h0});
		script.push_back('{ROW_REG,  OP_ALLOC, 11'd0,    32'hFFFF_F000, REG_BASE,  1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_REG,  OP_ALLOC, 11'd0,    32'hFFFF_FFFF, REG_COUNT, 1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd0,    32'h0000_0000, REG_BASE, 1'b1, ST_OK,
			32'hFFFF_F000});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd2,    32'h0000_0000, REG_BASE, 1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h0000_7000, REG_BASE, 1'b1,
			ST_BAD_FREE, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'hFFFF_F000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_REG,  OP_ALLOC, 11'd0,    32'h0000_0000, REG_COUNT, 1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd0,    32'h0000_0000, REG_BASE, 1'b1, ST_OK,
			32'hFFFF_F000});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1,    32'h0000_0000, REG_BASE, 1'b1,
			ST_NO_SPACE, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'hFFFF_F000, REG_BASE, 1'b1,
			ST_BAD_FREE, 32'h0});
		script.push_back('{ROW_REG,  OP_ALLOC, 11'd0,    32'h0000_0000, REG_BASE,  1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_REG,  OP_ALLOC, 11'd0,    32'h0000_0001, REG_COUNT, 1'b0, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_FREE,  11'd0,    32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1,    32'h0000_0000, REG_BASE, 1'b1, ST_OK, 32'h0});
		script.push_back('{ROW_WORD, OP_ALLOC, 11'd1,    32'h0000_0000, REG_BASE, 1'b1,
			ST_NO_SPACE, 32'h0});

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (script[i]) begin
			row = script[i];
			if (row.kind == ROW_REG) begin
				settle();
				write_reg(row.sel, row.addr);
			end else begin
				push_word(row.op, row.pages, row.addr, row.fixed, row.st, row.ga);
			end
		end

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p % 3)
				0: base = $urandom() & ~32'hFFF;
				1: base = $urandom();
				default: base = 32'hFFFF_FFFF - $urandom_range(0, 16 * PAGE_BYTES);
			endcase
			settle();
			write_reg(REG_BASE, base);
			write_reg(REG_COUNT, {21'($urandom()), 11'(PHASE_COUNT[p])});
			lim = (PHASE_COUNT[p] > MAX_FRAMES) ? MAX_FRAMES : PHASE_COUNT[p];
			for (int n = 0; n < PHASE_ITEMS[p]; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < 45 || (pick < 80 && live_runs.size() == 0)) begin
					case ($urandom_range(0, 19))
						0, 1: pages = '0;
						2, 3: pages = ENTRY_W'(lim);
						4: pages = ENTRY_W'(lim + 1);
						default: pages = ENTRY_W'($urandom_range(1,
							(lim < 8) ? 2 : ((lim > 256) ? 64 : lim / 4)));
					endcase
					push_word(OP_ALLOC, pages, $urandom());
				end else if (pick < 80) begin
					k = $urandom_range(0, live_runs.size() - 1);
					addr = base + ADDR_W'(live_runs[k]) * ADDR_W'(PAGE_BYTES);
					live_runs.delete(k);
					case ($urandom_range(0, 7))
						0: addr += $urandom_range(1, PAGE_BYTES - 1);
						1: addr += PAGE_BYTES;
						default: ;
					endcase
					push_word(OP_FREE, ENTRY_W'($urandom()), addr);
				end else begin
					case ($urandom_range(0, 3))
						0: push_word(OP_FREE, ENTRY_W'($urandom()), $urandom());
						1: push_word(OP_FREE, ENTRY_W'($urandom()),
							base + ADDR_W'($urandom_range(0, lim + 2)) * ADDR_W'(PAGE_BYTES)
							+ $urandom_range(0, PAGE_BYTES - 1));
						2: push_word(OP_FREE, ENTRY_W'($urandom()),
							base - $urandom_range(1, PAGE_BYTES));
						default: push_word(OP_ALLOC, ENTRY_W'($urandom_range(0, 2047)),
							$urandom());
					endcase
				end
			end
		end

		settle();
		repeat (2100) @(posedge clk);
		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> contiguous_page_frame_allocator.f
+incdir+hw/rtl
hw/rtl/cpfa_pkg.sv
hw/rtl/cpfa_ram.sv
hw/rtl/contiguous_page_frame_allocator.sv
tb/sv/contiguous_page_frame_allocator_tb.sv
